// File: rtl/core/vrmp_pkg.sv
package vrmp_pkg;

    localparam int unsigned DataW  = 16;
    localparam int unsigned IndexW = 3;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned SpeedW = 8;

    // Word register indexes of the port.
    localparam logic [IndexW-1:0] RegPointer  = 3'd0;
    localparam logic [IndexW-1:0] RegData     = 3'd1;
    localparam logic [IndexW-1:0] RegModulo   = 3'd2;
    localparam logic [IndexW-1:0] RegAnim     = 3'd3;
    localparam logic [IndexW-1:0] RegDataRd0  = 3'd4;
    localparam logic [IndexW-1:0] RegDataRd1  = 3'd5;

    localparam logic OpRead  = 1'b0;
    localparam logic OpWrite = 1'b1;

    // Fixed bit 7 of the animation register read value.
    localparam logic [7:0] AnimFlag = 8'h80;

    typedef struct packed {
        logic              operation;
        logic [IndexW-1:0] reg_index;
        logic              byte_access;
        logic              byte_odd;
        logic [DataW-1:0]  write_data;
        logic [PhaseW-1:0] frame_phase;
    } t_access;

    typedef struct packed {
        logic             en;
        logic [DataW-1:0] data;
    } t_mem_wr;

endpackage

// File: rtl/core/vrmp_vram.sv
module vrmp_vram #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_BITS-1:0]       i_waddr,
    input  logic [vrmp_pkg::DataW-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_BITS-1:0]       i_raddr,
    output logic [vrmp_pkg::DataW-1:0] o_rdata
);

    logic [vrmp_pkg::DataW-1:0] r_mem [0:(1 << ADDR_BITS)-1];
    logic [vrmp_pkg::DataW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/vrmp_clear.sv
module vrmp_clear #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    output logic                 o_busy,
    output logic [ADDR_BITS-1:0] o_addr
);

    logic                 r_busy;
    logic [ADDR_BITS-1:0] r_addr;

    // One word is zeroed per cycle, from the bottom of the memory up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            r_addr <= r_addr + 1'b1;
            if (&r_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_addr;

endmodule

// File: rtl/core/vrmp_exec.sv
module vrmp_exec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  vrmp_pkg::t_access          i_acc,
    input  logic [vrmp_pkg::DataW-1:0] i_word,
    output logic [vrmp_pkg::DataW-1:0] o_ptr,
    output logic [vrmp_pkg::DataW-1:0] o_next_ptr,
    output vrmp_pkg::t_mem_wr          o_mem_wr,
    output logic [vrmp_pkg::DataW-1:0] o_result
);

    logic [vrmp_pkg::DataW-1:0]  r_ptr;
    logic [vrmp_pkg::DataW-1:0]  r_step;
    logic [vrmp_pkg::SpeedW-1:0] r_speed;
    logic [vrmp_pkg::DataW-1:0]  n_ptr;
    logic [vrmp_pkg::DataW-1:0]  n_step;
    logic [vrmp_pkg::SpeedW-1:0] n_speed;
    logic [vrmp_pkg::DataW-1:0]  rd_val;
    logic [vrmp_pkg::DataW-1:0]  wr_val;
    logic                        wr_en;
    logic                        mem_we;

    always_comb begin
        unique case (i_acc.reg_index) inside
            vrmp_pkg::RegPointer, vrmp_pkg::RegData,
            vrmp_pkg::RegDataRd0, vrmp_pkg::RegDataRd1: rd_val = i_word;
            vrmp_pkg::RegModulo: rd_val = r_step;
            vrmp_pkg::RegAnim: rd_val = {r_speed, vrmp_pkg::AnimFlag[7:3], i_acc.frame_phase};
            default: rd_val = '0;
        endcase
    end

    // An even byte write merges its low byte into the register's read value.
    assign wr_en  = (i_acc.operation == vrmp_pkg::OpWrite)
                    && (!i_acc.byte_access || !i_acc.byte_odd);
    assign wr_val = i_acc.byte_access ? {rd_val[15:8], i_acc.write_data[7:0]}
                                      : i_acc.write_data;

    always_comb begin
        n_ptr   = r_ptr;
        n_step  = r_step;
        n_speed = r_speed;
        mem_we  = 1'b0;
        if (i_adv && wr_en) begin
            unique case (i_acc.reg_index)
                vrmp_pkg::RegPointer: n_ptr = wr_val;
                vrmp_pkg::RegData: begin
                    mem_we = 1'b1;
                    n_ptr  = r_ptr + r_step;
                end
                vrmp_pkg::RegModulo: n_step = wr_val;
                vrmp_pkg::RegAnim: n_speed = wr_val[15:8];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_step  <= '0;
            r_speed <= '0;
        end else begin
            r_ptr   <= n_ptr;
            r_step  <= n_step;
            r_speed <= n_speed;
        end
    end

    assign o_ptr         = r_ptr;
    assign o_next_ptr    = n_ptr;
    assign o_mem_wr.en   = mem_we;
    assign o_mem_wr.data = wr_val;
    assign o_result      = (i_acc.operation == vrmp_pkg::OpRead && !i_acc.byte_access)
                           ? rd_val : '0;

endmodule

// File: rtl/core/video_ram_modulo_port.sv
// An accepted access is registered in the execute stage, with its VRAM read, then in the
// output register. Throughput: one access per cycle unless the output stalls; the single
// synchronous VRAM read port is used once per access, and a VRAM write in the same cycle is
// forwarded to a read of the same word. Reset (i_rst_n low, synchronous) clears pointer,
// modulo and speed, then a clearing pass zeroes the VRAM one word a cycle, taking no access.
module video_ram_modulo_port #(
    parameter int unsigned VRAM_ADDR_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [vrmp_pkg::IndexW-1:0]         i_reg_index,
    input  logic                                i_byte_access,
    input  logic                                i_byte_odd,
    input  logic [vrmp_pkg::DataW-1:0]          i_write_data,
    input  logic [vrmp_pkg::PhaseW-1:0]         i_frame_phase,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [vrmp_pkg::DataW-1:0]          o_read_data
);

    logic                       r_b_valid;
    vrmp_pkg::t_access          r_b_acc;
    logic                       r_fwd_hit;
    logic [vrmp_pkg::DataW-1:0] r_fwd_data;
    logic                       r_out_valid;
    logic [vrmp_pkg::DataW-1:0] r_out_data;

    logic                       clr_busy;
    logic [VRAM_ADDR_BITS-1:0]  clr_addr;
    logic                       b_adv;
    logic                       in_acc;
    logic [vrmp_pkg::DataW-1:0] mem_q;
    logic [vrmp_pkg::DataW-1:0] word;
    logic [vrmp_pkg::DataW-1:0] ptr;
    logic [vrmp_pkg::DataW-1:0] next_ptr;
    logic [vrmp_pkg::DataW-1:0] result;
    vrmp_pkg::t_mem_wr          exec_wr;
    vrmp_pkg::t_access          in_acc_bus;
    logic                       mem_we;
    logic [VRAM_ADDR_BITS-1:0]  mem_waddr;
    logic [vrmp_pkg::DataW-1:0] mem_wdata;
    logic [VRAM_ADDR_BITS-1:0]  mem_raddr;

    assign b_adv      = r_b_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !clr_busy && (!r_b_valid || b_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_acc_bus.operation   = i_operation;
    assign in_acc_bus.reg_index   = i_reg_index;
    assign in_acc_bus.byte_access = i_byte_access;
    assign in_acc_bus.byte_odd    = i_byte_odd;
    assign in_acc_bus.write_data  = i_write_data;
    assign in_acc_bus.frame_phase = i_frame_phase;

    vrmp_clear #(
        .ADDR_BITS(VRAM_ADDR_BITS)
    ) u_clear (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .o_busy (clr_busy),
        .o_addr (clr_addr)
    );

    // The incoming beat reads at the pointer as it stands after the current write.
    assign mem_raddr = next_ptr[VRAM_ADDR_BITS-1:0];
    assign mem_we    = clr_busy || exec_wr.en;
    assign mem_waddr = clr_busy ? clr_addr : ptr[VRAM_ADDR_BITS-1:0];
    assign mem_wdata = clr_busy ? '0 : exec_wr.data;

    vrmp_vram #(
        .ADDR_BITS(VRAM_ADDR_BITS)
    ) u_vram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (in_acc),
        .i_raddr(mem_raddr),
        .o_rdata(mem_q)
    );

    assign word = r_fwd_hit ? r_fwd_data : mem_q;

    vrmp_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (b_adv),
        .i_acc     (r_b_acc),
        .i_word    (word),
        .o_ptr     (ptr),
        .o_next_ptr(next_ptr),
        .o_mem_wr  (exec_wr),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_b_valid <= 1'b1;
                r_fwd_hit <= exec_wr.en && (ptr[VRAM_ADDR_BITS-1:0] == mem_raddr);
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
                r_fwd_hit <= 1'b0;
            end
            if (b_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_acc    <= in_acc_bus;
            r_fwd_data <= exec_wr.data;
        end
        if (b_adv) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    a_no_exec_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !exec_wr.en)
        else $error("VRAM write from an access during the clearing pass");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_b_valid)
        else $error("accepted beat did not reach the execute stage");

    a_fwd_only_with_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_b_valid)
        else $error("forwarded word held without an access in the execute stage");

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_adv |=> r_out_valid)
        else $error("finished access did not reach the output register");

endmodule

// File: dv/tb_video_ram_modulo_port.sv
module tb_video_ram_modulo_port;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VramAddrBits = 16;
    localparam int unsigned VramDepth    = 1 << VramAddrBits;
    localparam int unsigned NumAccesses  = 1650;
    localparam int unsigned RunLimit     = 600000;
    localparam int unsigned SettleCycles = 8;

    localparam logic [vrmp_pkg::IndexW-1:0] RegSpare0 = 3'd6;
    localparam logic [vrmp_pkg::IndexW-1:0] RegSpare1 = 3'd7;
    localparam logic SizeWord = 1'b0;
    localparam logic SizeByte = 1'b1;
    localparam logic LaneEven = 1'b0;
    localparam logic LaneOdd  = 1'b1;

    typedef struct {
        vrmp_pkg::t_access acc;
        int unsigned       gap;
        bit                drain;
    } t_planned_access;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_ready;
    logic                        i_operation   = vrmp_pkg::OpRead;
    logic [vrmp_pkg::IndexW-1:0] i_reg_index   = '0;
    logic                        i_byte_access = SizeWord;
    logic                        i_byte_odd    = LaneEven;
    logic [vrmp_pkg::DataW-1:0]  i_write_data  = '0;
    logic [vrmp_pkg::PhaseW-1:0] i_frame_phase = '0;
    logic                        o_out_valid;
    logic                        i_out_ready   = 1'b0;
    logic [vrmp_pkg::DataW-1:0]  o_read_data;

    video_ram_modulo_port #(
        .VRAM_ADDR_BITS(VramAddrBits)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_reg_index  (i_reg_index),
        .i_byte_access(i_byte_access),
        .i_byte_odd   (i_byte_odd),
        .i_write_data (i_write_data),
        .i_frame_phase(i_frame_phase),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data)
    );

    // Shadow copy of the port state.
    bit [vrmp_pkg::DataW-1:0]  vram_image [VramDepth];
    bit [vrmp_pkg::DataW-1:0]  shadow_pointer;
    bit [vrmp_pkg::DataW-1:0]  shadow_step;
    bit [vrmp_pkg::SpeedW-1:0] shadow_speed;

    t_planned_access access_queue[$];
    logic [vrmp_pkg::DataW-1:0] expected_read_data[$];

    int unsigned error_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned reads_taken   = 0;
    int unsigned writes_taken  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned cycle_count   = 0;

    bit          sender_calm   = 1'b0;
    bit          drain_pending = 1'b0;
    bit          head_armed    = 1'b0;
    int unsigned hold_off      = 0;
    bit          stall_mode    = 1'b1;
    int unsigned stall_left    = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [vrmp_pkg::DataW-1:0] register_value(
        logic [vrmp_pkg::IndexW-1:0] idx, logic [vrmp_pkg::PhaseW-1:0] phase);
        case (idx) inside
            vrmp_pkg::RegPointer, vrmp_pkg::RegData,
            vrmp_pkg::RegDataRd0, vrmp_pkg::RegDataRd1: begin
                return vram_image[shadow_pointer & (VramDepth - 1)];
            end
            vrmp_pkg::RegModulo: begin
                return shadow_step;
            end
            vrmp_pkg::RegAnim: begin
                return {shadow_speed, vrmp_pkg::AnimFlag | {5'b0, phase}};
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    function automatic void register_write(logic [vrmp_pkg::IndexW-1:0] idx,
                                           logic [vrmp_pkg::DataW-1:0] data);
        case (idx)
            vrmp_pkg::RegPointer: begin
                shadow_pointer = data;
            end
            vrmp_pkg::RegData: begin
                vram_image[shadow_pointer & (VramDepth - 1)] = data;
                shadow_pointer = shadow_pointer + shadow_step;
            end
            vrmp_pkg::RegModulo: begin
                shadow_step = data;
            end
            vrmp_pkg::RegAnim: begin
                shadow_speed = data[15:8];
            end
            default: begin
            end
        endcase
    endfunction

    // Applies one accepted access to the shadow state and returns its read data.
    function automatic logic [vrmp_pkg::DataW-1:0] predict_access(vrmp_pkg::t_access acc);
        logic [vrmp_pkg::DataW-1:0] current;
        current = register_value(acc.reg_index, acc.frame_phase);
        if (acc.operation == vrmp_pkg::OpRead) begin
            return (acc.byte_access == SizeByte) ? '0 : current;
        end
        if (acc.byte_access == SizeWord) begin
            register_write(acc.reg_index, acc.write_data);
        end else if (acc.byte_odd == LaneEven) begin
            register_write(acc.reg_index, {current[15:8], acc.write_data[7:0]});
        end
        return '0;
    endfunction

    function automatic void queue_access(logic op, logic [vrmp_pkg::IndexW-1:0] idx,
                                         logic size, logic lane,
                                         logic [vrmp_pkg::DataW-1:0] data,
                                         logic [vrmp_pkg::PhaseW-1:0] phase);
        t_planned_access item;
        item.acc.operation   = op;
        item.acc.reg_index   = idx;
        item.acc.byte_access = size;
        item.acc.byte_odd    = lane;
        item.acc.write_data  = data;
        item.acc.frame_phase = phase;
        item.gap   = sender_calm ? 0 : $urandom_range(0, 15);
        item.drain = drain_pending;
        drain_pending = 1'b0;
        access_queue.push_back(item);
        if (access_queue.size() % 150 == 0) begin
            sender_calm = !sender_calm;
        end
    endfunction

    // Driver: presents one beat at a time after its planned gap; a drain beat waits for all results.
    always @(posedge i_clk) begin
        logic              fire;
        logic              launch;
        t_planned_access   nxt;
        vrmp_pkg::t_access taken;
        fire   = i_in_valid && o_in_ready;
        launch = 1'b0;
        if (fire) begin
            taken.operation   = i_operation;
            taken.reg_index   = i_reg_index;
            taken.byte_access = i_byte_access;
            taken.byte_odd    = i_byte_odd;
            taken.write_data  = i_write_data;
            taken.frame_phase = i_frame_phase;
            expected_read_data.push_back(predict_access(taken));
            if (taken.operation == vrmp_pkg::OpRead) reads_taken++;
            else writes_taken++;
            if (taken.byte_access == SizeByte) bytes_taken++;
        end
        if (i_rst_n && !(i_in_valid && !fire) && access_queue.size() != 0) begin
            if (!head_armed) begin
                hold_off   = access_queue[0].gap;
                head_armed = 1'b1;
            end
            if (hold_off != 0) begin
                hold_off--;
            end else if (!(access_queue[0].drain && (expected_read_data.size() != 0 || fire))) begin
                launch = 1'b1;
            end
        end
        if (launch) begin
            nxt        = access_queue.pop_front();
            head_armed = 1'b0;
            i_operation   <= nxt.acc.operation;
            i_reg_index   <= nxt.acc.reg_index;
            i_byte_access <= nxt.acc.byte_access;
            i_byte_odd    <= nxt.acc.byte_odd;
            i_write_data  <= nxt.acc.write_data;
            i_frame_phase <= nxt.acc.frame_phase;
            i_in_valid    <= 1'b1;
        end else if (fire) begin
            i_in_valid <= 1'b0;
        end
    end

    // Monitor: checks each result beat and stalls the result side at random.
    always @(posedge i_clk) begin
        logic [vrmp_pkg::DataW-1:0] want;
        if (i_out_ready && o_out_valid === 1'b1) begin
            if (expected_read_data.size() == 0) begin
                error_count++;
                $error("unexpected result beat, read_data actual %h", o_read_data);
            end else begin
                want = expected_read_data.pop_front();
                if (want !== o_read_data) begin
                    error_count++;
                    $error("read_data mismatch: expected %h, actual %h", want, o_read_data);
                end
            end
            results_seen++;
            stall_left = stall_mode ? $urandom_range(0, 15) : 0;
            if (results_seen % 200 == 0) stall_mode = !stall_mode;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == RunLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [vrmp_pkg::DataW-1:0]  base;
        logic [vrmp_pkg::DataW-1:0]  stride;
        logic [vrmp_pkg::IndexW-1:0] rd_idx;
        int unsigned                 burst_len;
        int unsigned                 next_drain_at;
        int unsigned                 planned_total;

        // Directed part: animation readback, pointer wrap both ways, byte merges.
        sender_calm = 1'b1;
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegAnim,    SizeWord, LaneEven, 16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegAnim,    SizeWord, LaneEven, 16'hFFFF, 3'd7);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegAnim,    SizeWord, LaneEven, 16'hFF00, 3'd2);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegAnim,    SizeWord, LaneEven, 16'h0000, 3'd5);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegAnim,    SizeByte, LaneEven, 16'h0012, 3'd3);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegAnim,    SizeByte, LaneEven, 16'h0000, 3'd1);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegPointer, SizeWord, LaneEven, 16'hFFFF, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegModulo,  SizeWord, LaneEven, 16'h0001, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegData,    SizeWord, LaneEven, 16'hFFFF, 3'd0);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegDataRd0, SizeWord, LaneEven, 16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegModulo,  SizeWord, LaneEven, 16'hFFFF, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegData,    SizeWord, LaneEven, 16'h5A5A, 3'd0);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegDataRd1, SizeWord, LaneEven, 16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegData,    SizeWord, LaneEven, 16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegModulo,  SizeWord, LaneEven, 16'h8000, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegData,    SizeWord, LaneEven, 16'h1234, 3'd0);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegModulo,  SizeWord, LaneEven, 16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegModulo,  SizeByte, LaneOdd,  16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegPointer, SizeByte, LaneOdd,  16'h00AB, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegPointer, SizeByte, LaneEven, 16'hFF00, 3'd0);
        queue_access(vrmp_pkg::OpRead,  vrmp_pkg::RegDataRd0, SizeWord, LaneEven, 16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegData,    SizeByte, LaneEven, 16'h00C3, 3'd0);
        queue_access(vrmp_pkg::OpWrite, RegSpare0,            SizeWord, LaneEven, 16'hFFFF, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegDataRd0, SizeWord, LaneEven, 16'hFFFF, 3'd0);
        queue_access(vrmp_pkg::OpRead,  RegSpare1,            SizeWord, LaneEven, 16'h0000, 3'd0);
        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegModulo,  SizeByte, LaneEven, 16'h0001, 3'd0);

        // Random part: mostly strided write bursts read back word by word.
        sender_calm   = 1'b0;
        drain_pending = 1'b1;
        next_drain_at = 600;
        while (access_queue.size() < NumAccesses) begin
            if (access_queue.size() >= next_drain_at) begin
                drain_pending = 1'b1;
                next_drain_at += 550;
            end
            case ($urandom_range(0, 9)) inside
                [0:3]: begin
                    base = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 63));
                    case ($urandom_range(0, 3))
                        0:       stride = 16'h0001;
                        1:       stride = 16'hFFFF;
                        2:       stride = 16'($urandom_range(0, 8));
                        default: stride = 16'($urandom);
                    endcase
                    burst_len = $urandom_range(1, 6);
                    queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegModulo, SizeWord, LaneEven,
                                 stride, 3'($urandom));
                    queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegPointer, SizeWord, LaneEven,
                                 base, 3'($urandom));
                    for (int k = 0; k < burst_len; k++) begin
                        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegData,
                                     ($urandom_range(0, 4) == 0) ? SizeByte : SizeWord,
                                     LaneEven, 16'($urandom), 3'($urandom));
                    end
                    for (int k = 0; k < burst_len; k++) begin
                        case ($urandom_range(0, 2))
                            0:       rd_idx = vrmp_pkg::RegData;
                            1:       rd_idx = vrmp_pkg::RegDataRd0;
                            default: rd_idx = vrmp_pkg::RegDataRd1;
                        endcase
                        queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegPointer, SizeWord,
                                     LaneEven, 16'(base + k * stride), 3'($urandom));
                        queue_access(vrmp_pkg::OpRead, rd_idx, SizeWord, LaneEven,
                                     16'($urandom), 3'($urandom));
                    end
                end
                4: begin
                    queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegAnim, 1'($urandom),
                                 1'($urandom), 16'($urandom), 3'($urandom));
                    queue_access(vrmp_pkg::OpRead, vrmp_pkg::RegAnim, SizeWord, LaneEven,
                                 16'($urandom), 3'($urandom));
                end
                5: begin
                    queue_access(vrmp_pkg::OpWrite, vrmp_pkg::RegModulo, 1'($urandom),
                                 1'($urandom), 16'($urandom), 3'($urandom));
                    queue_access(vrmp_pkg::OpRead, vrmp_pkg::RegModulo, SizeWord, LaneEven,
                                 16'($urandom), 3'($urandom));
                end
                6: begin
                    queue_access(1'($urandom), 3'($urandom), SizeByte, 1'($urandom),
                                 16'($urandom), 3'($urandom));
                end
                default: begin
                    queue_access(1'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                                 16'($urandom), 3'($urandom));
                end
            endcase
        end
        planned_total = access_queue.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every access answers with exactly one result beat.
        while (results_seen < planned_total) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);

        $display("Checked %0d result beats from %0d reads and %0d writes (%0d byte-wide).",
                 results_seen, reads_taken, writes_taken, bytes_taken);
        $display("Traffic mixed strided VRAM bursts, modulo wrap, animation reads and noise.");
        if (error_count == 0 && expected_read_data.size() == 0
            && results_seen == planned_total) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/vrmp_pkg.sv
rtl/core/vrmp_vram.sv
rtl/core/vrmp_clear.sv
rtl/core/vrmp_exec.sv
rtl/core/video_ram_modulo_port.sv
dv/tb_video_ram_modulo_port.sv
